>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under clock and active-low reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under clock and active-low reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/stpw_pkg.sv
// Package with widths, register map and constants of the stopwatch unit.
package stpw_pkg;

  localparam int unsigned CfgW      = 8;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned OnesW     = 4;
  localparam int unsigned TensW     = 3;

  localparam logic [OnesW-1:0] OnesLast = 4'd9;
  localparam logic [TensW-1:0] TensLast = 3'd5;

  localparam logic [CfgW-1:0] TicksPerSecondRst = 8'd4;
  localparam logic [CfgW-1:0] HoldTicksRst      = 8'd4;

  typedef enum logic {
    REG_TICKS_PER_SECOND = 1'b0,
    REG_HOLD_TICKS       = 1'b1
  } reg_idx_e;

  // Result fields, highest bit first.
  typedef struct packed {
    logic             holding;
    logic             led_lit;
    logic [TensW-1:0] tens_digit;
    logic [OnesW-1:0] ones_digit;
  } result_t;

endpackage

>>> rtl/stopwatch_hold_long_press_reset_unit.sv
// Top level of the BCD seconds stopwatch with hold button and long-press clear.
//
// Input stream (s_axis): one transaction carries a button change with its
// level and a timer tick. Output stream (m_axis): one transaction per input
// transaction, carrying the digits, LED and hold flag after that input.
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle unless the receiver stalls; all state
// updates are combinational, between the state registers and result register.
// The result register decouples the sides: a new input is taken while the
// previous result is being taken in the same cycle; while the receiver
// stalls with a result pending, s_axis_tready stays low and the result holds.
// APB port: ticks_per_second at 0x0, hold_ticks at 0x4, written in the
// access cycle; reads return the register values. pready is always high.
// Reset: digits, prescaler, long-press count, mode and LED clear, both
// registers return to 4, and no result is pending.
module stopwatch_hold_long_press_reset_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] button_event, [1] button_level, [2] tick, [7:3] zero
  input  logic [stpw_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] ones_digit, [6:4] tens_digit, [7] led_lit, [8] holding, [15:9] zero
  output logic [stpw_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stpw_pkg::PaddrW-1:0]   paddr,
  input  logic [stpw_pkg::PdataW-1:0]   pwdata,
  output logic [stpw_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  logic [stpw_pkg::CfgW-1:0]  tps_q, hold_ticks_q;
  logic                      hold_q, hold_d, pressed_q, pressed_d, led_q, led_d;
  logic [stpw_pkg::CfgW-1:0]  presc_q, presc_d, press_q, press_d;
  logic [stpw_pkg::OnesW-1:0] ones_q, ones_d;
  logic [stpw_pkg::TensW-1:0] tens_q, tens_d;
  logic                      out_valid_q;
  stpw_pkg::result_t         res_q, res_d;
  logic                      in_xfer, cfg_wr;
  logic                      ev, lvl, tk;
  stpw_pkg::reg_idx_e        reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = stpw_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      stpw_pkg::REG_TICKS_PER_SECOND: prdata = {{(stpw_pkg::PdataW-stpw_pkg::CfgW){1'b0}}, tps_q};
      stpw_pkg::REG_HOLD_TICKS:       prdata = {{(stpw_pkg::PdataW-stpw_pkg::CfgW){1'b0}},
                                                hold_ticks_q};
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= stpw_pkg::TicksPerSecondRst;
      hold_ticks_q <= stpw_pkg::HoldTicksRst;
    end else if (cfg_wr) begin
      if (reg_sel == stpw_pkg::REG_TICKS_PER_SECOND) begin
        tps_q <= pwdata[stpw_pkg::CfgW-1:0];
      end else begin
        hold_ticks_q <= pwdata[stpw_pkg::CfgW-1:0];
      end
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign ev            = s_axis_tdata[0];
  assign lvl           = s_axis_tdata[1];
  assign tk            = s_axis_tdata[2];

  // Button first, then tick: advance or LED blink, then long-press clear.
  always_comb begin
    hold_d    = hold_q;
    pressed_d = pressed_q;
    led_d     = led_q;
    presc_d   = presc_q;
    press_d   = press_q;
    ones_d    = ones_q;
    tens_d    = tens_q;
    if (ev) begin
      press_d = '0;
      if (lvl) begin
        if (!pressed_q) begin
          pressed_d = 1'b1;
          hold_d    = !hold_q;
          led_d     = !hold_q;
        end
      end else begin
        pressed_d = 1'b0;
      end
    end
    if (tk) begin
      if (!hold_d) begin
        presc_d = presc_q + 8'd1;
        if (presc_d == tps_q) begin
          presc_d = '0;
          if (ones_q >= stpw_pkg::OnesLast) begin
            ones_d = '0;
            tens_d = (tens_q >= stpw_pkg::TensLast) ? '0 : tens_q + 3'd1;
          end else begin
            ones_d = ones_q + 4'd1;
          end
        end
      end else begin
        led_d = !led_d;
      end
      if (pressed_d) begin
        press_d = press_d + 8'd1;
        if (press_d == hold_ticks_q) begin
          press_d = '0;
          ones_d  = '0;
          tens_d  = '0;
          presc_d = '0;
        end
      end
    end
    res_d.ones_digit = ones_d;
    res_d.tens_digit = tens_d;
    res_d.led_lit    = led_d;
    res_d.holding    = hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      pressed_q   <= 1'b0;
      led_q       <= 1'b0;
      presc_q     <= '0;
      press_q     <= '0;
      ones_q      <= '0;
      tens_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        hold_q      <= hold_d;
        pressed_q   <= pressed_d;
        led_q       <= led_d;
        presc_q     <= presc_d;
        press_q     <= press_d;
        ones_q      <= ones_d;
        tens_q      <= tens_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(stpw_pkg::OutDataW-$bits(stpw_pkg::result_t)){1'b0}}, res_q};

endmodule

>>> rtl/stpw_checker.sv
// Port-level checker for the stopwatch unit, with its bind.
`include "assert_macros.svh"

module stpw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [stpw_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))
  `ASSERT_NXT(a_result_follows, clk_i, rst_ni, in_xfer, m_axis_tvalid)
  `ASSERT_IMP(a_ready_rule, clk_i, rst_ni, 1'b1,
              s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `ASSERT_IMP(a_bcd_range, clk_i, rst_ni, m_axis_tvalid,
              m_axis_tdata[3:0] <= stpw_pkg::OnesLast && m_axis_tdata[6:4] <= stpw_pkg::TensLast)

endmodule

bind stopwatch_hold_long_press_reset_unit stpw_checker u_stpw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
